>>> sv/chb_pkg.sv
// Shared types, character codes and helpers for the chunked body decoder.
// No dependencies; used by every module of the block but chb_checker.
package chb_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam int HEX_BITS      = 4;

  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_SP  = 8'h20;
  localparam logic [7:0] CHR_TAB = 8'h09;

  typedef enum logic [3:0] {
    PH_SIZE_PRE = 4'd0,
    PH_SIZE_DIG = 4'd1,
    PH_DATA     = 4'd2,
    PH_DATA_CR  = 4'd3,
    PH_DATA_LF  = 4'd4,
    PH_FINAL_CR = 4'd5,
    PH_FINAL_LF = 4'd6,
    PH_DONE     = 4'd7,
    PH_ERROR    = 4'd8
  } phase_t;

  typedef struct packed {
    logic       error;
    logic       done_res;
    logic       consumed;
    logic       out_valid;
    logic [7:0] out_byte;
  } result_t;

  // bit 4 flags a legal hex digit, bits 3:0 carry its value
  function automatic logic [HEX_BITS:0] hex_digit(input logic [7:0] c);
    logic [HEX_BITS:0] r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

endpackage

>>> sv/chb_core.sv
// Decoder state and per-byte step logic: one byte in, one result out.
// Depends on chb_pkg.
module chb_core #(
  parameter int SIZE_BITS = chb_pkg::SIZE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       in_byte,
  output chb_pkg::result_t res
);

  chb_pkg::phase_t        phase, phase_next;
  logic [SIZE_BITS-1:0]   chunk_size_acc, chunk_size_acc_next;
  logic [SIZE_BITS-1:0]   bytes_left, bytes_left_next;
  logic                   cr_pending, cr_pending_next;
  logic                   digits_closed, digits_closed_next;

  logic                      ok;
  logic                      in_digits;
  logic                      is_ws;
  logic [chb_pkg::HEX_BITS:0] hd;
  logic [SIZE_BITS-1:0]      left_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= chb_pkg::PH_SIZE_PRE;
      chunk_size_acc <= '0;
      bytes_left     <= '0;
      cr_pending     <= 1'b0;
      digits_closed  <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      chunk_size_acc <= chunk_size_acc_next;
      bytes_left     <= bytes_left_next;
      cr_pending     <= cr_pending_next;
      digits_closed  <= digits_closed_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    chunk_size_acc_next = chunk_size_acc;
    bytes_left_next     = bytes_left;
    cr_pending_next     = cr_pending;
    digits_closed_next  = digits_closed;
    ok                  = 1'b1;
    res                 = '0;
    in_digits           = (phase == chb_pkg::PH_SIZE_DIG);
    is_ws               = (in_byte == chb_pkg::CHR_CR) || (in_byte == chb_pkg::CHR_LF) ||
                          (in_byte == chb_pkg::CHR_SP) || (in_byte == chb_pkg::CHR_TAB);
    hd                  = chb_pkg::hex_digit(in_byte);
    left_dec            = (bytes_left != '0) ? bytes_left - SIZE_BITS'(1) : bytes_left;

    case (phase)
      chb_pkg::PH_SIZE_PRE, chb_pkg::PH_SIZE_DIG: begin
        if (cr_pending && in_byte == chb_pkg::CHR_LF) begin
          // CR LF closes the size line
          cr_pending_next    = 1'b0;
          digits_closed_next = 1'b0;
          if (!in_digits || chunk_size_acc == '0) begin
            phase_next = chb_pkg::PH_FINAL_CR;
          end else begin
            bytes_left_next = chunk_size_acc;
            phase_next      = chb_pkg::PH_DATA;
          end
          chunk_size_acc_next = '0;
        end else begin
          cr_pending_next = 1'b0;
          if (is_ws) begin
            cr_pending_next = (in_byte == chb_pkg::CHR_CR);
            if (in_digits) begin
              digits_closed_next = 1'b1;
            end
          end else if (!hd[chb_pkg::HEX_BITS] || digits_closed ||
                       chunk_size_acc[SIZE_BITS-1 -: chb_pkg::HEX_BITS] != '0) begin
            ok = 1'b0;
          end else begin
            chunk_size_acc_next = {chunk_size_acc[SIZE_BITS-chb_pkg::HEX_BITS-1:0],
                                   hd[chb_pkg::HEX_BITS-1:0]};
            phase_next          = chb_pkg::PH_SIZE_DIG;
          end
        end
      end
      chb_pkg::PH_DATA: begin
        res.out_byte    = in_byte;
        res.out_valid   = 1'b1;
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          phase_next = chb_pkg::PH_DATA_CR;
        end
      end
      chb_pkg::PH_DATA_CR: begin
        if (in_byte == chb_pkg::CHR_CR) phase_next = chb_pkg::PH_DATA_LF;
        else ok = 1'b0;
      end
      chb_pkg::PH_DATA_LF: begin
        if (in_byte == chb_pkg::CHR_LF) phase_next = chb_pkg::PH_SIZE_PRE;
        else ok = 1'b0;
      end
      chb_pkg::PH_FINAL_CR: begin
        if (in_byte == chb_pkg::CHR_CR) phase_next = chb_pkg::PH_FINAL_LF;
        else ok = 1'b0;
      end
      chb_pkg::PH_FINAL_LF: begin
        if (in_byte == chb_pkg::CHR_LF) begin
          phase_next   = chb_pkg::PH_DONE;
          res.consumed = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (phase_next < chb_pkg::PH_DONE && ok) begin
      res.consumed = 1'b1;
    end
    if (!ok) begin
      phase_next    = chb_pkg::PH_ERROR;
      res.out_byte  = '0;
      res.out_valid = 1'b0;
      res.consumed  = 1'b0;
    end
    res.done_res = (phase_next == chb_pkg::PH_DONE);
    res.error    = (phase_next == chb_pkg::PH_ERROR);
  end

endmodule

>>> sv/chb_out_reg.sv
// Result register of the decoder: holds one result until the sink takes it.
// Depends on chb_pkg.
module chb_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  chb_pkg::result_t din,
  output logic             can_load,
  output logic             vld,
  input  logic             rdy,
  output chb_pkg::result_t dout
);

  // a held result may be replaced in the same cycle it is taken
  assign can_load = !vld || rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (can_load) begin
      vld <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      dout <= din;
    end
  end

endmodule

>>> sv/http_chunked_body_decoder.sv
// Each input byte passes the byte register, then the result register, to the m_ side.
// Throughput: one byte per cycle; the byte register, the step logic and the
// result register advance together whenever the result register can load.
// The size accumulator and down counter are SIZE_BITS wide; one decrement per payload byte.
// Reset: synchronous, clears the phase to the start of a size line, the
// counters and flags, and empties both pipeline registers.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = chb_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] consumed, [9] done_res,
                                 // [10] error, [15:11] zero
  output logic        m_tuser    // [0] out_valid
);

  logic             in_vld;
  logic [7:0]       in_byte;
  logic             out_can_load;
  logic             advance;
  chb_pkg::result_t step_res;
  chb_pkg::result_t out_res;

  assign advance  = in_vld && out_can_load;
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  chb_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .in_byte(in_byte),
    .res    (step_res)
  );

  chb_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (in_vld),
    .din     (step_res),
    .can_load(out_can_load),
    .vld     (m_tvalid),
    .rdy     (m_tready),
    .dout    (out_res)
  );

  assign m_tdata = {5'b0, out_res.error, out_res.done_res, out_res.consumed, out_res.out_byte};
  assign m_tuser = out_res.out_valid;

endmodule

>>> sv/chb_checker.sv
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on http_chunked_body_decoder port names only.
module chb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  logic err_seen;
  logic in_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
      in_seen  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && m_tdata[10]) err_seen <= 1'b1;
      if (s_tvalid && s_tready && s_tdata == s_tdata) in_seen <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_sticky_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && err_seen |-> m_tdata[10] && !m_tdata[8] && !m_tuser)
    else $error("error flag not sticky");

  a_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[8] && !m_tdata[9] && !m_tdata[10])
    else $error("payload byte with bad status");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[9] && m_tdata[10]) && (m_tuser || m_tdata[7:0] == 8'h00))
    else $error("done and error together or stray data byte");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> in_seen)
    else $error("result without any input transaction");

endmodule

bind http_chunked_body_decoder chb_checker u_chb_checker (.*);

>>> test/testbench.sv
// Self-checking bench for http_chunked_body_decoder: streams one chunked body byte by byte
// and checks every result transaction against a hand-written result or an in-bench decoder of the same format.
// Depends on chb_pkg (phase codes, character codes, result layout) and the DUT only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import chb_pkg::*;

  localparam int SZ          = SIZE_BITS_DEF;
  localparam int BODY_ITEMS  = 1400;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;   // want holds a hand-written result
    result_t    want;
  } stim_t;

  // a plain body byte: consumed, nothing else set
  localparam result_t BODY = '{error: 1'b0, done_res: 1'b0, consumed: 1'b1,
                               out_valid: 1'b0, out_byte: 8'h00};
  localparam result_t NONE = '0;

  localparam stim_t DIRECTED [21] = '{
    '{CHR_SP,  1'b1, BODY},   // first byte out of reset
    '{CHR_CR,  1'b0, NONE},   // lone CR
    '{CHR_TAB, 1'b0, NONE},
    '{CHR_LF,  1'b0, NONE},   // lone LF
    '{"0",     1'b0, NONE},   // leading zeros
    '{"0",     1'b0, NONE},
    '{"2",     1'b0, NONE},
    '{CHR_SP,  1'b0, NONE},   // whitespace after the digits
    '{CHR_CR,  1'b0, NONE},
    '{CHR_LF,  1'b0, NONE},
    '{8'h00, 1'b1, '{error: 1'b0, done_res: 1'b0, consumed: 1'b1,
                     out_valid: 1'b1, out_byte: 8'h00}},
    '{8'hFF, 1'b1, '{error: 1'b0, done_res: 1'b0, consumed: 1'b1,
                     out_valid: 1'b1, out_byte: 8'hFF}},
    '{CHR_CR,  1'b0, NONE},
    '{CHR_LF,  1'b0, NONE},
    '{CHR_TAB, 1'b0, NONE},
    '{"1",     1'b0, NONE},
    '{CHR_CR,  1'b0, NONE},
    '{CHR_LF,  1'b0, NONE},
    '{CHR_CR, 1'b1, '{error: 1'b0, done_res: 1'b0, consumed: 1'b1,
                      out_valid: 1'b1, out_byte: CHR_CR}},  // CR as payload
    '{CHR_CR,  1'b0, NONE},
    '{CHR_LF,  1'b0, NONE}
  };

  // the body cannot restart without a reset, so each run ends in exactly one of these
  typedef enum int {
    END_ZERO, END_EMPTY, END_SPLIT_DIGITS, END_EXTENSION, END_OVERFLOW,
    END_TRAILER, END_NO_DATA_CRLF, END_BAD_FINAL_LF, END_BAD_CHAR
  } body_end_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  stim_t   byte_q [$];
  result_t decoded_q [$];
  int      n_sent = 0;
  int      n_results = 0;
  int      n_errors = 0;
  int      stall_cycles = 0;

  // decoder state, at its reset values
  phase_t        ph = PH_SIZE_PRE;
  logic [SZ-1:0] size_acc = '0;
  logic [SZ-1:0] payload_left = '0;
  logic          saw_cr = 1'b0;
  logic          size_ended = 1'b0;

  http_chunked_body_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t decode_byte(input logic [7:0] c);
    result_t r;
    logic    ok;
    logic    in_dig;
    int      d;
    r  = '0;
    ok = 1'b1;
    case (ph)
      PH_SIZE_PRE, PH_SIZE_DIG: begin
        in_dig = (ph == PH_SIZE_DIG);
        if (saw_cr && c == CHR_LF) begin
          saw_cr = 1'b0;
          size_ended = 1'b0;
          if (!in_dig || size_acc == '0) begin
            ph = PH_FINAL_CR;
          end else begin
            payload_left = size_acc;
            ph = PH_DATA;
          end
          size_acc = '0;
        end else begin
          saw_cr = 1'b0;
          if (c == CHR_CR || c == CHR_LF || c == CHR_SP || c == CHR_TAB) begin
            if (c == CHR_CR) saw_cr = 1'b1;
            if (in_dig) size_ended = 1'b1;
          end else begin
            if (c >= "0" && c <= "9") d = c - "0";
            else if (c >= "a" && c <= "f") d = c - "a" + 10;
            else if (c >= "A" && c <= "F") d = c - "A" + 10;
            else d = -1;
            // a digit that would shift bits out of the accumulator overflows
            if (d < 0 || size_ended || size_acc[SZ-1 -: 4] != 4'h0) begin
              ok = 1'b0;
            end else begin
              size_acc = {size_acc[SZ-5:0], 4'(d)};
              ph = PH_SIZE_DIG;
            end
          end
        end
      end
      PH_DATA: begin
        r.out_byte  = c;
        r.out_valid = 1'b1;
        if (payload_left != '0) payload_left = payload_left - SZ'(1);
        if (payload_left == '0) ph = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (c == CHR_CR) ph = PH_DATA_LF; else ok = 1'b0;
      end
      PH_DATA_LF: begin
        if (c == CHR_LF) ph = PH_SIZE_PRE; else ok = 1'b0;
      end
      PH_FINAL_CR: begin
        if (c == CHR_CR) ph = PH_FINAL_LF; else ok = 1'b0;
      end
      PH_FINAL_LF: begin
        if (c == CHR_LF) begin
          ph = PH_DONE;
          r.consumed = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
      default: ;
    endcase
    if (ph < PH_DONE && ok) r.consumed = 1'b1;
    if (!ok) begin
      ph = PH_ERROR;
      r  = '0;
    end
    r.done_res = (ph == PH_DONE);
    r.error    = (ph == PH_ERROR);
    return r;
  endfunction

  task automatic add_byte(input logic [7:0] c);
    stim_t s;
    s = '{c, 1'b0, NONE};
    byte_q.insert(byte_q.size(), s);
  endtask

  // n whitespace bytes; never CR then LF, which would end the line
  task automatic add_ws(input int n);
    logic       prev_cr;
    logic [7:0] c;
    prev_cr = 1'b0;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(prev_cr ? 2 : 3))
        0:       c = CHR_SP;
        1:       c = CHR_TAB;
        2:       c = CHR_CR;
        default: c = CHR_LF;
      endcase
      prev_cr = (c == CHR_CR);
      add_byte(c);
    end
  endtask

  task automatic add_size_line(input logic [31:0] size, input int zeros);
    int         nd;
    logic [3:0] nib;
    logic [7:0] c;
    add_ws($urandom_range(2));
    repeat (zeros) add_byte("0");
    nd = 0;
    while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
    for (int i = nd - 1; i >= 0; i--) begin
      nib = size[4*i +: 4];
      if (nib < 4'd10) c = "0" + nib;
      else c = 8'(($urandom_range(1) ? "A" : "a") + nib - 10);
      add_byte(c);
    end
    add_ws($urandom_range(2));
    add_byte(CHR_CR);
    add_byte(CHR_LF);
  endtask

  task automatic add_payload(input int n);
    repeat (n) begin
      if ($urandom_range(7) == 0) add_byte($urandom_range(1) ? CHR_CR : CHR_LF);
      else add_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic build_body();
    int         r;
    int         size;
    logic [7:0] c;
    foreach (DIRECTED[i]) byte_q.insert(byte_q.size(), DIRECTED[i]);
    while (byte_q.size() < BODY_ITEMS) begin
      r = $urandom_range(99);
      if (r < 85) size = 1 + $urandom_range(23);
      else if (r < 97) size = 24 + $urandom_range(100);
      else size = 200 + $urandom_range(311);
      add_size_line(size, $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
      add_payload(size);
      add_byte(CHR_CR);
      add_byte(CHR_LF);
    end
    case (body_end_t'($urandom_range(END_BAD_CHAR)))
      END_ZERO: begin
        add_size_line(0, $urandom_range(1, 3));
        add_byte(CHR_CR);
        add_byte(CHR_LF);
      end
      END_EMPTY: begin
        add_ws($urandom_range(3));
        add_byte(CHR_CR);
        add_byte(CHR_LF);
        add_byte(CHR_CR);
        add_byte(CHR_LF);
      end
      END_SPLIT_DIGITS: begin
        add_byte("1");
        add_byte($urandom_range(1) ? CHR_SP : CHR_TAB);
        add_byte("2");
      end
      END_EXTENSION: begin
        add_byte("5");
        add_byte(";");
        add_byte("x");
      end
      END_OVERFLOW: begin
        // eight digits still fit, the ninth overflows
        add_byte("0");
        repeat (8) add_byte("F");
        add_byte("0");
      end
      END_TRAILER: begin
        add_size_line(0, 1);
        add_byte("X");
        add_byte(":");
      end
      END_NO_DATA_CRLF: begin
        add_size_line(2, 0);
        add_payload(2);
        do c = 8'($urandom_range(255)); while (c == CHR_CR);
        add_byte(c);
      end
      END_BAD_FINAL_LF: begin
        add_size_line(0, 1);
        add_byte(CHR_CR);
        do c = 8'($urandom_range(255)); while (c == CHR_LF);
        add_byte(c);
      end
      default: begin
        do c = 8'($urandom_range(255));
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
               c == CHR_CR || c == CHR_LF || c == CHR_SP || c == CHR_TAB);
        add_byte("0");
        add_byte(c);
      end
    endcase
    // everything past done or error is ignored
    repeat (16) add_byte(8'($urandom_range(255)));
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : send_proc
    stim_t   cur;
    result_t pred;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pred = decode_byte(cur.data);
        decoded_q.insert(decoded_q.size(), cur.typed ? cur.want : pred);
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (byte_q.size() != 0 &&
            ((n_sent >= 200 && n_sent < 500) || $urandom_range(99) >= 12)) begin
          cur = byte_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur.data;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : recv_proc
    result_t got;
    result_t want;
    int      hold_left;
    logic    hold_done;
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{error: m_tdata[10], done_res: m_tdata[9], consumed: m_tdata[8],
                out_valid: m_tuser, out_byte: m_tdata[7:0]};
        if (decoded_q.size() == 0) begin
          $display("%0t ns: unexpected transaction, expected none, got %0h", $time, got);
          n_errors++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte",  want.out_byte,  got.out_byte);
          check_field("out_valid", want.out_valid, got.out_valid);
          check_field("consumed",  want.consumed,  got.consumed);
          check_field("done_res",  want.done_res,  got.done_res);
          check_field("error",     want.error,     got.error);
        end
        n_results++;
      end
      // one long hold-off lets the pipeline fill and back up into s_tready
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && n_results >= 900) begin
        hold_done = 1'b1;
        hold_left = 150;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (n_results >= 200 && n_results < 500) || $urandom_range(99) >= 12;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    build_body();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (byte_q.size() != 0 || s_tvalid) @(negedge clk);
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
